FILE: hdl/rrwl_pkg.sv
`timescale 1ns / 1ps
// Package for the recursive reader-writer lock manager.
// Shared types, request and status codes, fixed port widths. No dependencies.
package rrwl_pkg;

   localparam int THREADS_DEF    = 16;
   localparam int COUNT_BITS_DEF = 8;

   localparam int TID_W   = 4;
   localparam int MASK_W  = 16;
   localparam int TOTAL_W = 8;

   typedef enum logic [1:0] {
      FN_READ_LOCK     = 2'd0,
      FN_WRITE_LOCK    = 2'd1,
      FN_READ_RELEASE  = 2'd2,
      FN_WRITE_RELEASE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE   = 2'd0,
      ST_QUEUED = 2'd1,
      ST_ERROR  = 2'd2
   } status_type;

   typedef struct packed {
      status_type         status;
      logic               woke_any;
      logic [MASK_W-1:0]  woken_mask;
      logic               writer_held;
      logic [TID_W-1:0]   writer_thread;
      logic [TOTAL_W-1:0] reader_total;
      logic [TOTAL_W-1:0] recursion_depth;
   } rsp_type;

endpackage

FILE: hdl/recursive_reader_writer_lock.sv
`timescale 1ns / 1ps
// Recursive reader-writer lock manager, top level.
// Depends on rrwl_pkg.
//
// One lock shared by THREADS numbered threads. Every request (read lock, write lock,
// read release, write release) is decided in the cycle it is accepted and its response
// is registered into the output register, or into the skid buffer while that one waits,
// so one request per cycle is sustained while req_stall is low. The response side has an
// output register plus a one-entry skid buffer, so requests keep flowing while one
// response waits; req_stall rises only once both hold a response. Waiting writers sit
// in a THREADS-deep queue whose head entry is read ahead into a register. Counters are
// COUNT_BITS wide and reported on 8-bit ports (low bits). No clearing pass after reset.
module recursive_reader_writer_lock #(
   parameter int THREADS    = rrwl_pkg::THREADS_DEF,
   parameter int COUNT_BITS = rrwl_pkg::COUNT_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_func,
   input  logic [rrwl_pkg::TID_W-1:0]  req_thread_id,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_woke_any,
   output logic [rrwl_pkg::MASK_W-1:0] rsp_woken_mask,
   output logic                        rsp_writer_held,
   output logic [rrwl_pkg::TID_W-1:0]  rsp_writer_thread,
   output logic [rrwl_pkg::TOTAL_W-1:0] rsp_reader_total,
   output logic [rrwl_pkg::TOTAL_W-1:0] rsp_recursion_depth
);

   localparam int PTR_W  = $clog2(THREADS);
   localparam int USED_W = $clog2(THREADS + 1);
   localparam int SUM_W  = ((COUNT_BITS > USED_W) ? COUNT_BITS : USED_W) + 1;
   localparam int MEXT_W = THREADS + rrwl_pkg::MASK_W;
   localparam int CEXT_W = COUNT_BITS + rrwl_pkg::TOTAL_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [PTR_W-1:0]      PTR_LAST = PTR_W'(THREADS - 1);

   // lock state
   logic                       owner_valid_ff, owner_valid_in;
   logic [rrwl_pkg::TID_W-1:0] owner_thread_ff, owner_thread_in;
   logic [COUNT_BITS-1:0]      nest_ff, nest_in;
   logic [COUNT_BITS-1:0]      readers_ff, readers_in;
   logic [THREADS-1:0]         wait_mask_ff, wait_mask_in;
   logic [USED_W-1:0]          wait_cnt_ff, wait_cnt_in;
   logic [PTR_W-1:0]           head_ff, head_in;
   logic [PTR_W-1:0]           tail_ff, tail_in;
   logic [USED_W-1:0]          used_ff, used_in;

   // writer queue and read-ahead of its head
   logic [rrwl_pkg::TID_W-1:0] fifo_mem [THREADS];
   logic [rrwl_pkg::TID_W-1:0] head_tid_ff;
   logic                       enq;

   // response buffering
   rrwl_pkg::rsp_type out_ff, skid_ff, rsp_new;
   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   logic              acc, take;

   rrwl_pkg::status_type   status;
   logic [THREADS-1:0]     woken;
   logic [MEXT_W-1:0]      woken_ext;
   logic [CEXT_W-1:0]      readers_ext, nest_ext;

   assign req_stall = skid_valid_ff;
   assign acc       = req_valid & ~skid_valid_ff;
   assign take      = out_valid_ff & ~rsp_stall;

   always_comb begin
      logic               tid_ok;
      logic [THREADS-1:0] tid_bit;
      logic [SUM_W-1:0]   sum;
      rrwl_pkg::func_type fn;

      fn      = rrwl_pkg::func_type'(req_func);
      tid_ok  = (32'(req_thread_id) < THREADS);
      tid_bit = THREADS'(1) << req_thread_id;
      sum     = SUM_W'(readers_ff) + SUM_W'(wait_cnt_ff);

      owner_valid_in  = owner_valid_ff;
      owner_thread_in = owner_thread_ff;
      nest_in         = nest_ff;
      readers_in      = readers_ff;
      wait_mask_in    = wait_mask_ff;
      wait_cnt_in     = wait_cnt_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      used_in         = used_ff;
      enq             = 1'b0;
      status          = rrwl_pkg::ST_DONE;
      woken           = '0;

      unique case (fn)
         rrwl_pkg::FN_READ_LOCK: begin
            priority if (!tid_ok) begin
               status = rrwl_pkg::ST_ERROR;
            end else if (owner_valid_ff && owner_thread_ff == req_thread_id) begin
               if (nest_ff == CNT_MAX) status = rrwl_pkg::ST_ERROR;
               else nest_in = nest_ff + 1'b1;
            end else if (owner_valid_ff) begin
               wait_mask_in = wait_mask_ff | tid_bit;
               if ((wait_mask_ff & tid_bit) == '0) wait_cnt_in = wait_cnt_ff + 1'b1;
               status = rrwl_pkg::ST_QUEUED;
            end else if (readers_ff == CNT_MAX) begin
               status = rrwl_pkg::ST_ERROR;
            end else begin
               readers_in = readers_ff + 1'b1;
            end
         end
         rrwl_pkg::FN_WRITE_LOCK: begin
            priority if (!tid_ok) begin
               status = rrwl_pkg::ST_ERROR;
            end else if (owner_valid_ff && owner_thread_ff == req_thread_id) begin
               if (nest_ff == CNT_MAX) status = rrwl_pkg::ST_ERROR;
               else nest_in = nest_ff + 1'b1;
            end else if (owner_valid_ff || readers_ff != '0) begin
               if (used_ff == USED_W'(THREADS)) begin
                  status = rrwl_pkg::ST_ERROR;
               end else begin
                  enq     = 1'b1;
                  tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
                  used_in = used_ff + 1'b1;
                  status  = rrwl_pkg::ST_QUEUED;
               end
            end else begin
               owner_valid_in  = 1'b1;
               owner_thread_in = req_thread_id;
            end
         end
         rrwl_pkg::FN_READ_RELEASE: begin
            priority if (owner_valid_ff) begin
               if (nest_ff == '0) status = rrwl_pkg::ST_ERROR;
               else nest_in = nest_ff - 1'b1;
            end else if (readers_ff == '0) begin
               status = rrwl_pkg::ST_ERROR;
            end else begin
               readers_in = readers_ff - 1'b1;
               if (readers_ff == COUNT_BITS'(1) && used_ff != '0) begin
                  head_in         = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
                  used_in         = used_ff - 1'b1;
                  owner_valid_in  = 1'b1;
                  owner_thread_in = head_tid_ff;
                  woken           = THREADS'(1) << head_tid_ff;
               end
            end
         end
         rrwl_pkg::FN_WRITE_RELEASE: begin
            priority if (nest_ff != '0) begin
               nest_in = nest_ff - 1'b1;
            end else if (!owner_valid_ff) begin
               status = rrwl_pkg::ST_ERROR;
            end else if (used_ff != '0) begin
               head_in         = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
               used_in         = used_ff - 1'b1;
               owner_thread_in = head_tid_ff;
               woken           = THREADS'(1) << head_tid_ff;
            end else begin
               owner_valid_in  = 1'b0;
               owner_thread_in = '0;
               woken           = wait_mask_ff;
               wait_mask_in    = '0;
               wait_cnt_in     = '0;
               readers_in      = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_BITS-1:0];
            end
         end
         default: status = rrwl_pkg::ST_ERROR;
      endcase
   end

   assign woken_ext   = MEXT_W'(woken);
   assign readers_ext = CEXT_W'(readers_in);
   assign nest_ext    = CEXT_W'(nest_in);

   always_comb begin
      rsp_new.status          = status;
      rsp_new.woke_any        = (woken != '0);
      rsp_new.woken_mask      = woken_ext[rrwl_pkg::MASK_W-1:0];
      rsp_new.writer_held     = owner_valid_in;
      rsp_new.writer_thread   = owner_valid_in ? owner_thread_in : '0;
      rsp_new.reader_total    = readers_ext[rrwl_pkg::TOTAL_W-1:0];
      rsp_new.recursion_depth = nest_ext[rrwl_pkg::TOTAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owner_valid_ff  <= 1'b0;
         owner_thread_ff <= '0;
         nest_ff         <= '0;
         readers_ff      <= '0;
         wait_mask_ff    <= '0;
         wait_cnt_ff     <= '0;
         head_ff         <= '0;
         tail_ff         <= '0;
         used_ff         <= '0;
      end else if (acc) begin
         owner_valid_ff  <= owner_valid_in;
         owner_thread_ff <= owner_thread_in;
         nest_ff         <= nest_in;
         readers_ff      <= readers_in;
         wait_mask_ff    <= wait_mask_in;
         wait_cnt_ff     <= wait_cnt_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         used_ff         <= used_in;
      end
   end

   // queue storage; head entry read ahead, bypassed when written into an empty queue
   always_ff @(posedge clock) begin
      if (acc && enq) begin
         fifo_mem[tail_ff] <= req_thread_id;
      end
      if (acc && enq && tail_ff == head_in) begin
         head_tid_ff <= req_thread_id;
      end else if (acc) begin
         head_tid_ff <= fifo_mem[head_in];
      end else begin
         head_tid_ff <= fifo_mem[head_ff];
      end
   end

   // output register and skid entry
   always_comb begin
      skid_valid_in = skid_valid_ff;
      out_valid_in  = out_valid_ff & ~take;
      if (skid_valid_ff && take) begin
         skid_valid_in = 1'b0;
         out_valid_in  = 1'b1;
      end else if (acc) begin
         if (!out_valid_ff || take) out_valid_in = 1'b1;
         else skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff && take) begin
         out_ff <= skid_ff;
      end else if (acc && (!out_valid_ff || take)) begin
         out_ff <= rsp_new;
      end
      if (acc && out_valid_ff && !take) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_ff.status;
   assign rsp_woke_any        = out_ff.woke_any;
   assign rsp_woken_mask      = out_ff.woken_mask;
   assign rsp_writer_held     = out_ff.writer_held;
   assign rsp_writer_thread   = out_ff.writer_thread;
   assign rsp_reader_total    = out_ff.reader_total;
   assign rsp_recursion_depth = out_ff.recursion_depth;

endmodule

FILE: hdl/rrwl_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the lock manager, bound to its top level.
// Depends on rrwl_pkg and recursive_reader_writer_lock.
module rrwl_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic                         rsp_woke_any,
   input logic [rrwl_pkg::MASK_W-1:0]  rsp_woken_mask,
   input logic                         rsp_writer_held,
   input logic [rrwl_pkg::TID_W-1:0]   rsp_writer_thread,
   input logic [rrwl_pkg::TOTAL_W-1:0] rsp_reader_total,
   input logic [rrwl_pkg::TOTAL_W-1:0] rsp_recursion_depth
);

   a_woke_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_woke_any == (rsp_woken_mask != '0)))
      else $error("woke_any disagrees with woken_mask");

   a_no_owner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_writer_held |-> rsp_writer_thread == '0 && rsp_recursion_depth == '0)
      else $error("owner fields set with no writer");

   a_quiet_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rrwl_pkg::ST_ERROR || rsp_status == rrwl_pkg::ST_QUEUED)
      |-> !rsp_woke_any)
      else $error("waiters woken by a queued or failed request");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_woken_mask)
      && $stable(rsp_reader_total) && $stable(rsp_writer_thread))
      else $error("stalled response changed");

endmodule

bind recursive_reader_writer_lock rrwl_checker u_rrwl_checker (.*);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for recursive_reader_writer_lock: directed table, then random
// and saturating request sequences checked against an in-bench lock predictor.
// Depends on rrwl_pkg and the recursive_reader_writer_lock RTL.
module tb;

   localparam int unsigned COUNT_TOP = (1 << rrwl_pkg::COUNT_BITS_DEF) - 1;

   typedef logic [rrwl_pkg::TID_W-1:0]   tid_type;
   typedef logic [rrwl_pkg::MASK_W-1:0]  mask_type;
   typedef logic [rrwl_pkg::TOTAL_W-1:0] total_type;

   typedef struct {
      rrwl_pkg::func_type f;
      tid_type            tid;
      bit                 typed;
      rrwl_pkg::rsp_type  want;
   } script_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_func;
   tid_type              req_thread_id;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic                 rsp_woke_any;
   mask_type             rsp_woken_mask;
   logic                 rsp_writer_held;
   tid_type              rsp_writer_thread;
   total_type            rsp_reader_total;
   total_type            rsp_recursion_depth;

   // typed-in answer travelling with the current request
   bit                   typed_now;
   rrwl_pkg::rsp_type    typed_rsp;

   // predictor state
   logic                 lock_owned;
   tid_type              lock_owner;
   int unsigned          nest_depth;
   int unsigned          readers_in;
   mask_type             readers_waiting;
   tid_type              writers_waiting[$];

   rrwl_pkg::rsp_type    lock_answers[$];
   int                   errors;
   int                   sender_calm;

   always #10 clock = ~clock;

   recursive_reader_writer_lock u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_thread_id       (req_thread_id),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_woke_any        (rsp_woke_any),
      .rsp_woken_mask      (rsp_woken_mask),
      .rsp_writer_held     (rsp_writer_held),
      .rsp_writer_thread   (rsp_writer_thread),
      .rsp_reader_total    (rsp_reader_total),
      .rsp_recursion_depth (rsp_recursion_depth)
   );

   function automatic script_row_type plain(rrwl_pkg::func_type f, tid_type tid);
      script_row_type row;
      row.f     = f;
      row.tid   = tid;
      row.typed = 1'b0;
      row.want  = '0;
      return row;
   endfunction

   function automatic script_row_type known(rrwl_pkg::func_type f, tid_type tid,
                                            rrwl_pkg::status_type s, mask_type mask,
                                            logic held, tid_type owner, total_type readers,
                                            total_type depth);
      script_row_type row;
      row.f                    = f;
      row.tid                  = tid;
      row.typed                = 1'b1;
      row.want.status          = s;
      row.want.woke_any        = |mask;
      row.want.woken_mask      = mask;
      row.want.writer_held     = held;
      row.want.writer_thread   = owner;
      row.want.reader_total    = readers;
      row.want.recursion_depth = depth;
      return row;
   endfunction

   // oldest queued writer takes the lock
   function automatic mask_type hand_over();
      mask_type bit_set;
      bit_set    = '0;
      lock_owner = writers_waiting.pop_front();
      lock_owned = 1'b1;
      bit_set[lock_owner] = 1'b1;
      return bit_set;
   endfunction

   function automatic rrwl_pkg::rsp_type apply_lock_request(rrwl_pkg::func_type f,
                                                            tid_type tid);
      rrwl_pkg::rsp_type r;
      mask_type          woken;
      int unsigned       admitted;
      r        = '0;
      woken    = '0;
      r.status = rrwl_pkg::ST_DONE;
      if ((f == rrwl_pkg::FN_READ_LOCK || f == rrwl_pkg::FN_WRITE_LOCK) &&
          int'(tid) >= rrwl_pkg::THREADS_DEF) begin
         r.status = rrwl_pkg::ST_ERROR;
      end else begin
         case (f)
            rrwl_pkg::FN_READ_LOCK: begin
               if (lock_owned) begin
                  if (lock_owner == tid) begin
                     if (nest_depth >= COUNT_TOP) r.status = rrwl_pkg::ST_ERROR;
                     else nest_depth++;
                  end else begin
                     readers_waiting[tid] = 1'b1;
                     r.status = rrwl_pkg::ST_QUEUED;
                  end
               end else if (readers_in >= COUNT_TOP) begin
                  r.status = rrwl_pkg::ST_ERROR;
               end else begin
                  readers_in++;
               end
            end
            rrwl_pkg::FN_WRITE_LOCK: begin
               if (lock_owned && lock_owner == tid) begin
                  if (nest_depth >= COUNT_TOP) r.status = rrwl_pkg::ST_ERROR;
                  else nest_depth++;
               end else if (lock_owned || readers_in != 0) begin
                  if (writers_waiting.size() >= rrwl_pkg::THREADS_DEF) begin
                     r.status = rrwl_pkg::ST_ERROR;
                  end else begin
                     writers_waiting.push_back(tid);
                     r.status = rrwl_pkg::ST_QUEUED;
                  end
               end else begin
                  lock_owned = 1'b1;
                  lock_owner = tid;
               end
            end
            rrwl_pkg::FN_READ_RELEASE: begin
               if (lock_owned) begin
                  if (nest_depth == 0) r.status = rrwl_pkg::ST_ERROR;
                  else nest_depth--;
               end else if (readers_in == 0) begin
                  r.status = rrwl_pkg::ST_ERROR;
               end else begin
                  readers_in--;
                  if (readers_in == 0 && writers_waiting.size() != 0) woken = hand_over();
               end
            end
            default: begin
               if (nest_depth != 0) begin
                  nest_depth--;
               end else if (!lock_owned) begin
                  r.status = rrwl_pkg::ST_ERROR;
               end else if (writers_waiting.size() != 0) begin
                  woken = hand_over();
               end else begin
                  lock_owned      = 1'b0;
                  lock_owner      = '0;
                  woken           = readers_waiting;
                  admitted        = $countones(readers_waiting);
                  readers_waiting = '0;
                  if (admitted > COUNT_TOP - readers_in) readers_in = COUNT_TOP;
                  else readers_in = readers_in + admitted;
               end
            end
         endcase
      end
      r.woke_any        = |woken;
      r.woken_mask      = woken;
      r.writer_held     = lock_owned;
      r.writer_thread   = lock_owned ? lock_owner : '0;
      r.reader_total    = total_type'(readers_in);
      r.recursion_depth = total_type'(nest_depth);
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      errors++;
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
   endtask

   task automatic compare_answer(rrwl_pkg::rsp_type want);
      if (rsp_status != want.status) flag_mismatch("status", rsp_status, want.status);
      if (rsp_woke_any != want.woke_any) flag_mismatch("woke_any", rsp_woke_any, want.woke_any);
      if (rsp_woken_mask != want.woken_mask)
         flag_mismatch("woken_mask", rsp_woken_mask, want.woken_mask);
      if (rsp_writer_held != want.writer_held)
         flag_mismatch("writer_held", rsp_writer_held, want.writer_held);
      if (rsp_writer_thread != want.writer_thread)
         flag_mismatch("writer_thread", rsp_writer_thread, want.writer_thread);
      if (rsp_reader_total != want.reader_total)
         flag_mismatch("reader_total", rsp_reader_total, want.reader_total);
      if (rsp_recursion_depth != want.recursion_depth)
         flag_mismatch("recursion_depth", rsp_recursion_depth, want.recursion_depth);
   endtask

   // mostly back to back, some short gaps, a few long ones, and calm stretches
   function automatic int idle_span(inout int calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic issue_request(rrwl_pkg::func_type f, tid_type tid, bit typed,
                                rrwl_pkg::rsp_type want);
      int gap;
      gap = idle_span(sender_calm);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_func      = f;
      req_thread_id = tid;
      typed_now     = typed;
      typed_rsp     = want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_answers();
      req_valid = 1'b0;
      while (lock_answers.size() != 0) @(negedge clock);
   endtask

   // release until nobody holds or waits for the lock
   task automatic settle_lock();
      while (lock_owned || readers_in != 0 || writers_waiting.size() != 0) begin
         issue_request(lock_owned ? rrwl_pkg::FN_WRITE_RELEASE : rrwl_pkg::FN_READ_RELEASE,
                       tid_type'($urandom_range(0, 15)), 1'b0, '0);
      end
   endtask

   task automatic random_burst(int count);
      int                 r;
      rrwl_pkg::func_type f;
      tid_type            tid;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            f = rrwl_pkg::func_type'($urandom_range(0, 3));
         else if (lock_owned)
            f = (r < 30) ? rrwl_pkg::FN_READ_LOCK : (r < 55) ? rrwl_pkg::FN_WRITE_LOCK :
                (r < 70) ? rrwl_pkg::FN_READ_RELEASE : rrwl_pkg::FN_WRITE_RELEASE;
         else if (readers_in != 0)
            f = (r < 38) ? rrwl_pkg::FN_READ_LOCK : (r < 56) ? rrwl_pkg::FN_WRITE_LOCK :
                (r < 90) ? rrwl_pkg::FN_READ_RELEASE : rrwl_pkg::FN_WRITE_RELEASE;
         else
            f = (r < 45) ? rrwl_pkg::FN_READ_LOCK : (r < 85) ? rrwl_pkg::FN_WRITE_LOCK :
                (r < 93) ? rrwl_pkg::FN_READ_RELEASE : rrwl_pkg::FN_WRITE_RELEASE;
         tid = (lock_owned && $urandom_range(0, 9) < 4) ? lock_owner
                                                        : tid_type'($urandom_range(0, 15));
         issue_request(f, tid, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin : watch
      rrwl_pkg::rsp_type want;
      if (!reset && req_valid && !req_stall) begin
         want = apply_lock_request(rrwl_pkg::func_type'(req_func), req_thread_id);
         if (typed_now) want = typed_rsp;
         lock_answers.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lock_answers.size() == 0) flag_mismatch("unrequested response", 1, 0);
         else compare_answer(lock_answers.pop_front());
      end
   end

   initial begin : receiver
      int span;
      int calm;
      calm      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         span = idle_span(calm);
         if (span > 0) begin
            rsp_stall = 1'b1;
            repeat (span) @(negedge clock);
         end
         rsp_stall = 1'b0;
      end
   end

   initial begin : stimulus
      script_row_type script[$];
      tid_type        anchor;
      tid_type        tid;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_func        = rrwl_pkg::FN_READ_LOCK;
      req_thread_id   = '0;
      typed_now       = 1'b0;
      typed_rsp       = '0;
      errors          = 0;
      sender_calm     = 0;
      lock_owned      = 1'b0;
      lock_owner      = '0;
      nest_depth      = 0;
      readers_in      = 0;
      readers_waiting = '0;

      script.push_back(known(rrwl_pkg::FN_READ_RELEASE, 4'd0, rrwl_pkg::ST_ERROR,
                             16'h0000, 1'b0, 4'd0, 8'd0, 8'd0));
      script.push_back(known(rrwl_pkg::FN_WRITE_RELEASE, 4'd15, rrwl_pkg::ST_ERROR,
                             16'h0000, 1'b0, 4'd0, 8'd0, 8'd0));
      script.push_back(known(rrwl_pkg::FN_READ_LOCK, 4'd0, rrwl_pkg::ST_DONE,
                             16'h0000, 1'b0, 4'd0, 8'd1, 8'd0));
      script.push_back(known(rrwl_pkg::FN_READ_LOCK, 4'd15, rrwl_pkg::ST_DONE,
                             16'h0000, 1'b0, 4'd0, 8'd2, 8'd0));
      script.push_back(known(rrwl_pkg::FN_WRITE_LOCK, 4'd5, rrwl_pkg::ST_QUEUED,
                             16'h0000, 1'b0, 4'd0, 8'd2, 8'd0));
      script.push_back(known(rrwl_pkg::FN_WRITE_LOCK, 4'd5, rrwl_pkg::ST_QUEUED,
                             16'h0000, 1'b0, 4'd0, 8'd2, 8'd0));
      script.push_back(known(rrwl_pkg::FN_READ_RELEASE, 4'd3, rrwl_pkg::ST_DONE,
                             16'h0000, 1'b0, 4'd0, 8'd1, 8'd0));
      script.push_back(known(rrwl_pkg::FN_READ_RELEASE, 4'd0, rrwl_pkg::ST_DONE,
                             16'h0020, 1'b1, 4'd5, 8'd0, 8'd0));
      script.push_back(plain(rrwl_pkg::FN_READ_LOCK,     4'd5));
      script.push_back(plain(rrwl_pkg::FN_WRITE_LOCK,    4'd5));
      script.push_back(plain(rrwl_pkg::FN_READ_LOCK,     4'd9));
      script.push_back(plain(rrwl_pkg::FN_READ_LOCK,     4'd9));
      script.push_back(plain(rrwl_pkg::FN_READ_LOCK,     4'd0));
      script.push_back(plain(rrwl_pkg::FN_READ_RELEASE,  4'd7));
      script.push_back(plain(rrwl_pkg::FN_WRITE_RELEASE, 4'd0));
      script.push_back(known(rrwl_pkg::FN_READ_RELEASE, 4'd0, rrwl_pkg::ST_ERROR,
                             16'h0000, 1'b1, 4'd5, 8'd0, 8'd0));
      script.push_back(plain(rrwl_pkg::FN_WRITE_RELEASE, 4'd2));
      script.push_back(plain(rrwl_pkg::FN_WRITE_RELEASE, 4'd8));
      script.push_back(plain(rrwl_pkg::FN_WRITE_LOCK,    4'd12));
      script.push_back(plain(rrwl_pkg::FN_READ_RELEASE,  4'd4));
      script.push_back(plain(rrwl_pkg::FN_READ_RELEASE,  4'd6));
      script.push_back(plain(rrwl_pkg::FN_WRITE_LOCK,    4'd12));
      script.push_back(plain(rrwl_pkg::FN_WRITE_RELEASE, 4'd1));
      script.push_back(known(rrwl_pkg::FN_WRITE_RELEASE, 4'd11, rrwl_pkg::ST_DONE,
                             16'h0000, 1'b0, 4'd0, 8'd0, 8'd0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         issue_request(script[i].f, script[i].tid, script[i].typed, script[i].want);
      end

      random_burst(40);
      drain_answers();

      // fill the writer queue past its depth behind one owner
      settle_lock();
      anchor = tid_type'($urandom_range(0, 15));
      issue_request(rrwl_pkg::FN_WRITE_LOCK, anchor, 1'b0, '0);
      repeat (rrwl_pkg::THREADS_DEF + 3) begin
         tid = tid_type'($urandom_range(0, 15));
         if (tid == anchor) tid = tid + 1'b1;
         issue_request(rrwl_pkg::FN_WRITE_LOCK, tid, 1'b0, '0);
      end
      settle_lock();

      random_burst(30);

      // owner recursion up to its ceiling and back down
      settle_lock();
      anchor = tid_type'($urandom_range(0, 15));
      issue_request(rrwl_pkg::FN_WRITE_LOCK, anchor, 1'b0, '0);
      while (nest_depth < COUNT_TOP)
         issue_request($urandom_range(0, 1) ? rrwl_pkg::FN_WRITE_LOCK : rrwl_pkg::FN_READ_LOCK,
                       ($urandom_range(0, 19) == 0) ? tid_type'($urandom_range(0, 15)) : anchor,
                       1'b0, '0);
      repeat (2) issue_request(rrwl_pkg::FN_READ_LOCK, anchor, 1'b0, '0);
      repeat (2) issue_request(rrwl_pkg::FN_WRITE_LOCK, anchor, 1'b0, '0);
      while (nest_depth != 0)
         issue_request($urandom_range(0, 1) ? rrwl_pkg::FN_WRITE_RELEASE
                                            : rrwl_pkg::FN_READ_RELEASE,
                       tid_type'($urandom_range(0, 15)), 1'b0, '0);
      settle_lock();

      // reader count up to its ceiling
      while (readers_in < COUNT_TOP)
         issue_request(($urandom_range(0, 19) == 0) ? rrwl_pkg::FN_WRITE_LOCK
                                                    : rrwl_pkg::FN_READ_LOCK,
                       tid_type'($urandom_range(0, 15)), 1'b0, '0);
      repeat (3) issue_request(rrwl_pkg::FN_READ_LOCK, tid_type'($urandom_range(0, 15)),
                               1'b0, '0);

      drain_answers();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("recursive_reader_writer_lock regression: pass");
      end else begin
         $display("recursive_reader_writer_lock regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #20ms;
      $display("recursive_reader_writer_lock regression: fail");
      $finish;
   end

endmodule
